@@ src/assert_macros.svh @@
// assertion macros shared by the rtl files of the dfpwm bit decoder
// checks are compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ src/dfpwm_pkg.sv @@
// shared types and constants of the dfpwm bit decoder
// no dependencies
`default_nettype none

package dfpwm_pkg;

   localparam int BITS_PER_ITEM_DEF = 8;

   localparam int CSR_IDX_W = 2;

   // register reset values
   localparam logic [7:0] RISE_RATE_RST   = 8'd7;
   localparam logic [7:0] FALL_RATE_RST   = 8'd20;
   localparam logic [7:0] FILTER_GAIN_RST = 8'd100;

   // targets of the charge and the strength
   localparam logic signed [8:0] TARGET_HIGH  = 9'sd127;
   localparam logic signed [8:0] TARGET_LOW   = -9'sd128;
   localparam logic signed [8:0] STRENGTH_MAX = 9'sd255;
   localparam logic signed [8:0] STRENGTH_MIN = 9'sd0;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RISE_RATE   = 2'd0,
      CSR_FALL_RATE   = 2'd1,
      CSR_FILTER_GAIN = 2'd2
   } csr_idx_type;

   // one request to the shared step unit
   typedef struct packed {
      logic signed [8:0] cur;
      logic signed [8:0] goal;
      logic [7:0]        rate;
      logic              nudge_en;
   } step_req_type;

endpackage

`default_nettype wire

@@ src/dfpwm_if.sv @@
// valid/ready channel interfaces of the dfpwm bit decoder
// depends on dfpwm_pkg
`default_nettype none

// compressed byte in
interface dfpwm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] packed_bits;
   modport source (output valid, output packed_bits, input ready);
   modport sink (input valid, input packed_bits, output ready);
endinterface

// decoded sample out
interface dfpwm_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] sample_out;
   logic              last_of_byte;
   modport source (output valid, output sample_out, output last_of_byte, input ready);
   modport sink (input valid, input sample_out, input last_of_byte, output ready);
endinterface

// register write channel
interface dfpwm_csr_if;
   import dfpwm_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [7:0]           data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/dfpwm_step.sv @@
// shared step unit: moves a value toward a goal by rate/256, rounded,
// with an optional stall nudge; depends on dfpwm_pkg
`default_nettype none

module dfpwm_step (
   input  dfpwm_pkg::step_req_type req,
   output logic signed [8:0]       result
);
   import dfpwm_pkg::*;

   logic signed [9:0]  diff;
   logic signed [18:0] prod;
   logic signed [18:0] prod_rnd;
   logic signed [10:0] step;
   logic signed [10:0] moved;

   // distance to goal scaled by rate, rounded to nearest, ties upward
   always_comb begin
      diff     = {req.goal[8], req.goal} - {req.cur[8], req.cur};
      prod     = $signed({11'd0, req.rate}) * 19'(diff);
      prod_rnd = prod + 19'sd128;
      step     = prod_rnd[18:8];
      moved    = 11'(req.cur) + step;
   end

   // nudge by one toward the goal when the step stalls short of it
   always_comb begin
      if (req.nudge_en && (step == 11'sd0) && (req.cur != req.goal)) begin
         if (req.goal > req.cur) begin
            result = req.cur + 9'sd1;
         end else begin
            result = req.cur - 9'sd1;
         end
      end else begin
         result = moved[8:0];
      end
   end

endmodule

`default_nettype wire

@@ src/dfpwm_bit_decoder.sv @@
// dfpwm bit decoder top level: sequencer, state and output register
// depends on dfpwm_pkg, dfpwm_if, dfpwm_step and assert_macros.svh
//
// Usage:
//   req_chan carries one compressed word (packed_bits); bit 0 is decoded first.
//   rsp_chan returns BITS_PER_ITEM signed samples per word, last_of_byte set
//   on the final one. csr_chan writes rise_rate (0), fall_rate (1) and
//   filter_gain (2); other indexes are ignored. csr_chan is always ready.
//   Each bit takes three passes through one shared multiply-round unit:
//   charge, strength, then the low-pass filter. After a word is accepted,
//   the sequencer runs these passes bit by bit, and each filter pass loads
//   its sample into the output register that drives rsp_chan.
//   req_chan is ready only while the sequencer is idle, so the next word may
//   be taken while the last sample still waits in the output register.
//   When rsp_chan stalls, the sequencer holds at the filter pass until the
//   output register is free; no sample is lost or repeated.
//   Reset (synchronous, active high) clears charge, strength, filter level and
//   the previous target, and loads the register defaults 7, 20 and 100.
`default_nettype none
`include "assert_macros.svh"

module dfpwm_bit_decoder #(
   parameter int BITS_PER_ITEM = dfpwm_pkg::BITS_PER_ITEM_DEF
) (
   input  wire           clock,
   input  wire           reset,
   dfpwm_req_if.sink     req_chan,
   dfpwm_rsp_if.source   rsp_chan,
   dfpwm_csr_if.sink     csr_chan
);
   import dfpwm_pkg::*;

   localparam int CNT_W = $clog2(BITS_PER_ITEM + 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(BITS_PER_ITEM - 1);

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_CHARGE   = 4'b0010,
      ST_STRENGTH = 4'b0100,
      ST_FILTER   = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [7:0]        rise_ff, fall_ff, gain_ff;
   logic signed [7:0] charge_ff, charge_in;
   logic signed [7:0] prev_charge_ff, prev_charge_in;
   logic [7:0]        strength_ff, strength_in;
   logic signed [7:0] level_ff, level_in;
   logic              last_high_ff, last_high_in;
   logic [7:0]        bits_ff, bits_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [7:0] rsp_sample_ff, rsp_sample_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              high;
   logic              flip;
   logic              req_fire;
   logic              rsp_fire;
   logic              out_free;
   logic signed [8:0] avg_sum;
   logic signed [8:0] pre;
   step_req_type      step_req;
   logic signed [8:0] step_res;

   // handshakes
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sample_out   = rsp_sample_ff;
   assign rsp_chan.last_of_byte = rsp_last_ff;

   // current bit and flip against the previous target
   assign high    = bits_ff[0];
   assign flip    = (high != last_high_ff);
   assign avg_sum = 9'(charge_ff) + 9'(prev_charge_ff);
   assign pre     = flip ? (avg_sum >>> 1) : 9'(charge_ff);

   // operand selection for the shared unit
   always_comb begin
      step_req = '0;
      case (state_ff)
         ST_CHARGE: begin
            step_req.cur      = 9'(charge_ff);
            step_req.goal     = high ? TARGET_HIGH : TARGET_LOW;
            step_req.rate     = strength_ff;
            step_req.nudge_en = 1'b1;
         end
         ST_STRENGTH: begin
            step_req.cur      = $signed({1'b0, strength_ff});
            step_req.goal     = flip ? STRENGTH_MIN : STRENGTH_MAX;
            step_req.rate     = flip ? fall_ff : rise_ff;
            step_req.nudge_en = 1'b1;
         end
         ST_FILTER: begin
            step_req.cur      = 9'(level_ff);
            step_req.goal     = pre;
            step_req.rate     = gain_ff;
            step_req.nudge_en = 1'b0;
         end
         default: begin
            step_req = '0;
         end
      endcase
   end

   dfpwm_step u_step (
      .req    (step_req),
      .result (step_res)
   );

   // sequencer and state updates
   always_comb begin
      state_in       = state_ff;
      charge_in      = charge_ff;
      prev_charge_in = prev_charge_ff;
      strength_in    = strength_ff;
      level_in       = level_ff;
      last_high_in   = last_high_ff;
      bits_in        = bits_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_fire;
      rsp_sample_in  = rsp_sample_ff;
      rsp_last_in    = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               bits_in  = req_chan.packed_bits;
               cnt_in   = '0;
               state_in = ST_CHARGE;
            end
         end
         ST_CHARGE: begin
            prev_charge_in = charge_ff;
            charge_in      = step_res[7:0];
            state_in       = ST_STRENGTH;
         end
         ST_STRENGTH: begin
            strength_in = step_res[7:0];
            state_in    = ST_FILTER;
         end
         ST_FILTER: begin
            if (out_free) begin
               level_in      = step_res[7:0];
               rsp_valid_in  = 1'b1;
               rsp_sample_in = step_res[7:0];
               rsp_last_in   = (cnt_ff == LAST_CNT);
               last_high_in  = high;
               bits_in       = {1'b0, bits_ff[7:1]};
               cnt_in        = cnt_ff + 1'b1;
               state_in      = (cnt_ff == LAST_CNT) ? ST_IDLE : ST_CHARGE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         charge_ff    <= '0;
         strength_ff  <= '0;
         level_ff     <= '0;
         last_high_ff <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         charge_ff    <= charge_in;
         strength_ff  <= strength_in;
         level_ff     <= level_in;
         last_high_ff <= last_high_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working word and output payload
   always_ff @(posedge clock) begin
      prev_charge_ff <= prev_charge_in;
      bits_ff        <= bits_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rise_ff <= RISE_RATE_RST;
         fall_ff <= FALL_RATE_RST;
         gain_ff <= FILTER_GAIN_RST;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            CSR_RISE_RATE:   rise_ff <= csr_chan.data;
            CSR_FALL_RATE:   fall_ff <= csr_chan.data;
            CSR_FILTER_GAIN: gain_ff <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   // checks
   `ASSERT_NEXT(a_accept_starts, clock, reset, req_fire, state_ff == ST_CHARGE)
   `ASSERT_IMPLIES(a_word_from_filter, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == ST_FILTER)
   `ASSERT_ALWAYS(a_cnt_range, clock, reset, (state_ff == ST_IDLE) || (cnt_ff <= LAST_CNT))
   `ASSERT_IMPLIES(a_stall_holds, clock, reset,
      (state_ff == ST_FILTER) && rsp_valid_ff && !rsp_chan.ready,
      state_in == ST_FILTER)

endmodule

`default_nettype wire
